[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a boolean condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// Check a full property expression outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`endif

[rtl/u8d_pkg.sv]
package u8d_pkg;

	localparam int unsigned CpW   = 21;
	localparam int unsigned UsedW = 3;
	localparam int unsigned AvW   = 3;
	localparam int unsigned Lanes = 4;

	localparam logic [CpW-1:0]   REPL_CHAR = 21'h00FFFD;
	localparam logic [CpW-1:0]   CP_MAX    = 21'h10FFFF;
	localparam logic [UsedW-1:0] USED_NONE = 3'd0;
	localparam logic [UsedW-1:0] USED_ONE  = 3'd1;
	localparam logic [UsedW-1:0] USED_TWO  = 3'd2;
	localparam logic [UsedW-1:0] USED_THR  = 3'd3;
	localparam logic [UsedW-1:0] USED_FOUR = 3'd4;

	// per-byte classification, one per lane
	typedef struct packed {
		logic       is_cont;
		logic       is_ascii;
		logic       lead2;
		logic       lead3;
		logic       lead4;
		logic [5:0] payload;
	} lane_info_t;

endpackage

[rtl/u8d_lane.sv]
module u8d_lane (
	input  logic [7:0]          data_byte,
	output u8d_pkg::lane_info_t info
);
	import u8d_pkg::*;

	always_comb begin
		info.is_cont  = (data_byte[7:6] == 2'b10);
		info.is_ascii = ~data_byte[7];
		info.lead2    = (data_byte[7:5] == 3'b110);
		info.lead3    = (data_byte[7:4] == 4'b1110);
		info.lead4    = (data_byte[7:3] == 5'b11110);
		info.payload  = data_byte[5:0];
	end

endmodule

[rtl/u8d_merge.sv]
module u8d_merge (
	input  u8d_pkg::lane_info_t [3:0]         lanes,
	input  logic [7:0]                        lead_byte,
	input  logic [7:0]                        second_byte,
	input  logic [u8d_pkg::AvW-1:0]           bytes_available,
	output logic [u8d_pkg::CpW-1:0]           code_point,
	output logic [u8d_pkg::UsedW-1:0]         bytes_consumed
);
	import u8d_pkg::*;

	logic [CpW-1:0] v2, v3, v4;
	logic           ok2, ok3, ok4;

	always_comb begin
		v2 = {10'd0, lead_byte[4:0], lanes[1].payload};
		v3 = {5'd0, lead_byte[3:0], lanes[1].payload, lanes[2].payload};
		v4 = {lead_byte[2:0], lanes[1].payload, lanes[2].payload, lanes[3].payload};

		ok2 = (lead_byte >= 8'hC2) && lanes[1].is_cont;

		ok3 = lanes[1].is_cont && lanes[2].is_cont;
		if (lead_byte == 8'hE0 && !(second_byte inside {[8'hA0:8'hBF]}))
			ok3 = 1'b0;
		if (lead_byte == 8'hED && second_byte > 8'h9F)
			ok3 = 1'b0;

		ok4 = lanes[1].is_cont && lanes[2].is_cont && lanes[3].is_cont;
		if (lead_byte > 8'hF4)
			ok4 = 1'b0;
		if (lead_byte == 8'hF0 && !(second_byte inside {[8'h90:8'hBF]}))
			ok4 = 1'b0;
		if (lead_byte == 8'hF4 && second_byte > 8'h8F)
			ok4 = 1'b0;
		// reject surrogates and anything past the last plane
		if (v4[20:11] == 10'h01B || v4 > CP_MAX)
			ok4 = 1'b0;

		code_point     = REPL_CHAR;
		bytes_consumed = USED_ONE;
		if (lanes[0].is_ascii) begin
			code_point = {13'd0, lead_byte};
		end else if (lanes[0].lead2) begin
			if (bytes_available >= 3'd2) begin
				bytes_consumed = USED_TWO;
				if (ok2)
					code_point = v2;
			end
		end else if (lanes[0].lead3) begin
			if (bytes_available >= 3'd3) begin
				bytes_consumed = USED_THR;
				if (ok3)
					code_point = v3;
			end
		end else if (lanes[0].lead4) begin
			if (bytes_available >= 3'd4) begin
				bytes_consumed = USED_FOUR;
				if (ok4)
					code_point = v4;
			end
		end else begin
			code_point     = '0;
			bytes_consumed = USED_NONE;
		end
	end

endmodule

[rtl/utf8_char_decoder_core.sv]
// Stage 1 registers an accepted word; stage 2 holds its result word on m_tvalid.
// Throughput: one word per cycle unless m_tready stalls the output; four byte lanes
// classify in stage 1 and the merge stage assembles the code point in stage 2.
// Reset: arst_n asynchronously clears both stage valid flags; payload is not reset.
// s_tready follows m_tready while both stages hold words.
module utf8_char_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// lead_byte[7:0], second_byte[15:8], third_byte[23:16], fourth_byte[31:24],
	// bytes_available[34:32], zero fill[39:35]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// code_point[20:0], bytes_consumed[23:21]
	output logic [23:0] m_tdata
);
	import u8d_pkg::*;

	lane_info_t [Lanes-1:0] lanes;
	lane_info_t [Lanes-1:0] lanes_s1;
	logic [7:0]             lead_s1;
	logic [7:0]             second_s1;
	logic [AvW-1:0]         avail_s1;
	logic                   valid_s1;
	logic                   out_valid_q;
	logic [23:0]            out_data_q;
	logic [CpW-1:0]         cp;
	logic [UsedW-1:0]       used;
	logic                   adv_s2;
	logic                   adv_s1;

	for (genvar i = 0; i < Lanes; i++) begin : g_lane
		u8d_lane u_lane (
			.data_byte (s_tdata[8*i +: 8]),
			.info      (lanes[i])
		);
	end

	u8d_merge u_merge (
		.lanes           (lanes_s1),
		.lead_byte       (lead_s1),
		.second_byte     (second_s1),
		.bytes_available (avail_s1),
		.code_point      (cp),
		.bytes_consumed  (used)
	);

	assign adv_s2   = !out_valid_q || m_tready;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= s_tvalid;
			if (adv_s2)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_tvalid) begin
			lanes_s1  <= lanes;
			lead_s1   <= s_tdata[7:0];
			second_s1 <= s_tdata[15:8];
			avail_s1  <= s_tdata[34:32];
		end
		if (adv_s2 && valid_s1)
			out_data_q <= {used, cp};
	end

endmodule

[rtl/u8d_checker.sv]
`include "assert_macros.svh"

module u8d_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);

	logic [2:0]  used;
	logic [20:0] cp;
	logic        one_byte_ok;

	assign used        = m_tdata[23:21];
	assign cp          = m_tdata[20:0];
	assign one_byte_ok = (cp < 21'h80) || (cp == 21'h00FFFD);

	// hold a stalled result word
	`ASSERT_PROP(a_out_hold, clk, arst_n, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)))
	// an empty output register always takes a word
	`ASSERT_ALWAYS(a_ready_when_empty, clk, arst_n, (m_tvalid || s_tready))
	`ASSERT_ALWAYS(a_bad_lead_zero, clk, arst_n, (!m_tvalid || used != 3'd0 || cp == 21'd0))
	`ASSERT_ALWAYS(a_one_byte_cp, clk, arst_n, (!m_tvalid || used != 3'd1 || one_byte_ok))
	`ASSERT_ALWAYS(a_cp_max, clk, arst_n, (!m_tvalid || cp <= 21'h10FFFF))

endmodule

bind utf8_char_decoder_core u8d_checker u_u8d_checker (.*);

[verif/tb_utf8_char_decoder_core.sv]
module tb_utf8_char_decoder_core;
	timeunit 1ns;
	timeprecision 1ps;

	import u8d_pkg::*;

	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned HoldOffCycles = 300;
	localparam int unsigned HoldOffAfter = 150;

	// one input window, lead byte in the lowest bits as on s_tdata
	typedef struct packed {
		logic [AvW-1:0] avail;
		logic [7:0]     b3;
		logic [7:0]     b2;
		logic [7:0]     b1;
		logic [7:0]     b0;
	} char_window_t;

	typedef struct packed {
		logic [UsedW-1:0] used;
		logic [CpW-1:0]   cp;
	} char_result_t;

	typedef enum int {WELL_FORMED, BROKEN, NOISE} window_kind_e;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	char_window_t pending_windows[$];
	char_result_t expected_chars[$];
	int unsigned  mismatches = 0;
	int unsigned  windows_in = 0;
	int unsigned  cycles = 0;
	logic         in_fire = 1'b0;

	utf8_char_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic is_cont(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	function automatic char_result_t decode_char(input char_window_t w);
		char_result_t r;
		logic         ok;
		logic [CpW-1:0] v;
		r.cp = REPL_CHAR;
		r.used = USED_NONE;
		ok = 1'b1;
		if (!w.b0[7]) begin
			r.cp = CpW'(w.b0);
			r.used = USED_ONE;
		end else if (w.b0[7:5] == 3'b110) begin
			if (w.avail < 2) begin
				r.used = USED_ONE;
			end else begin
				r.used = USED_TWO;
				if (w.b0 >= 8'hC2 && is_cont(w.b1))
					r.cp = CpW'({w.b0[4:0], w.b1[5:0]});
			end
		end else if (w.b0[7:4] == 4'b1110) begin
			if (w.avail < 3) begin
				r.used = USED_ONE;
			end else begin
				r.used = USED_THR;
				if (w.b0 == 8'hE0 && (w.b1 < 8'hA0 || w.b1 > 8'hBF))
					ok = 1'b0;
				if (w.b0 == 8'hED && w.b1 > 8'h9F)
					ok = 1'b0;
				if (!is_cont(w.b1) || !is_cont(w.b2))
					ok = 1'b0;
				if (ok)
					r.cp = CpW'({w.b0[3:0], w.b1[5:0], w.b2[5:0]});
			end
		end else if (w.b0[7:3] == 5'b11110) begin
			if (w.avail < 4) begin
				r.used = USED_ONE;
			end else begin
				r.used = USED_FOUR;
				if (w.b0 > 8'hF4)
					ok = 1'b0;
				if (w.b0 == 8'hF0 && (w.b1 < 8'h90 || w.b1 > 8'hBF))
					ok = 1'b0;
				if (w.b0 == 8'hF4 && w.b1 > 8'h8F)
					ok = 1'b0;
				if (!is_cont(w.b1) || !is_cont(w.b2) || !is_cont(w.b3))
					ok = 1'b0;
				v = {w.b0[2:0], w.b1[5:0], w.b2[5:0], w.b3[5:0]};
				if ((v & 21'h1FF800) == 21'h00D800 || v > CP_MAX)
					ok = 1'b0;
				if (ok)
					r.cp = v;
			end
		end else begin
			// stray continuation or F8-FF lead
			r.cp = '0;
			r.used = USED_NONE;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string field, input int unsigned got,
		input int unsigned want);
		$display("ERROR at %0t: %s got 0x%0h, want 0x%0h", $realtime, field, got, want);
		mismatches++;
	endtask

	task automatic add_window(input logic [7:0] b0, input logic [7:0] b1,
		input logic [7:0] b2, input logic [7:0] b3, input logic [AvW-1:0] av);
		char_window_t w;
		w.b0 = b0;
		w.b1 = b1;
		w.b2 = b2;
		w.b3 = b3;
		w.avail = av;
		pending_windows.insert(pending_windows.size(), w);
	endtask

	// predict on input acceptance, check on output acceptance
	always @(posedge clk) begin
		cycles <= cycles + 1;
		in_fire <= s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			expected_chars.insert(expected_chars.size(),
				decode_char(char_window_t'(s_tdata[34:0])));
			windows_in <= windows_in + 1;
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_chars.size() == 0) begin
				report_mismatch("unexpected word", 32'(m_tdata), 0);
			end else begin
				if (m_tdata[20:0] != expected_chars[0].cp)
					report_mismatch("code_point", 32'(m_tdata[20:0]),
						32'(expected_chars[0].cp));
				if (m_tdata[23:21] != expected_chars[0].used)
					report_mismatch("bytes_consumed", 32'(m_tdata[23:21]),
						32'(expected_chars[0].used));
				void'(expected_chars.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// sender: bursts of random length separated by random gaps
	int burst_left = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_fire)) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_windows.size() > 0) begin
				s_tdata <= {5'b0, pending_windows.pop_front()};
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver: switches between stall patterns, plus one long hold-off
	int  rx_mode = 0;
	int  rx_mode_left = 0;
	int  hold_left = 0;
	logic hold_done = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && windows_in >= HoldOffAfter) begin
				hold_done = 1'b1;
				hold_left = HoldOffCycles;
				m_tready <= 1'b0;
			end else begin
				if (rx_mode_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_mode_left = $urandom_range(10, 60);
				end else begin
					rx_mode_left--;
				end
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	initial begin
		char_window_t w;
		window_kind_e kind;
		logic [CpW-1:0] cp;
		int len;
		int waited;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;

		// ascii, invalid leads, availability zero and above four
		add_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd0);
		add_window(8'h7F, 8'h80, 8'h80, 8'h80, 3'd7);
		add_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);
		add_window(8'hBF, 8'hBF, 8'hBF, 8'hBF, 3'd1);
		add_window(8'hF8, 8'h80, 8'h80, 8'h80, 3'd4);
		add_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
		// two-byte forms
		add_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
		add_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd5);
		add_window(8'hC0, 8'h80, 8'h00, 8'h00, 3'd2);
		add_window(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd4);
		add_window(8'hC2, 8'h41, 8'h00, 8'h00, 3'd2);
		add_window(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd1);
		add_window(8'hC3, 8'hA9, 8'h00, 8'h00, 3'd0);
		// three-byte forms, overlong and surrogate edges
		add_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
		add_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd3);
		add_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd6);
		add_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd3);
		add_window(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd4);
		add_window(8'hE1, 8'h80, 8'hC0, 8'h00, 3'd3);
		add_window(8'hE1, 8'h80, 8'h80, 8'h00, 3'd2);
		// four-byte forms, range edges and F5 and F7 leads
		add_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
		add_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4);
		add_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd7);
		add_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);
		add_window(8'hF7, 8'hBF, 8'hBF, 8'hBF, 3'd4);
		add_window(8'hF1, 8'h80, 8'h80, 8'hC0, 3'd4);
		add_window(8'hF5, 8'h80, 8'h80, 8'h80, 3'd3);

		for (int i = 0; i < 400; i++) begin
			w = char_window_t'(35'({$urandom, $urandom}));
			case ($urandom_range(0, 9))
				7: kind = BROKEN;
				8, 9: kind = NOISE;
				default: kind = WELL_FORMED;
			endcase
			if (kind != NOISE) begin
				len = $urandom_range(1, 4);
				case (len)
					1: cp = CpW'($urandom_range(0, 'h7F));
					2: cp = CpW'($urandom_range('h80, 'h7FF));
					3: begin
						cp = CpW'($urandom_range('h800, 'hFFFF));
						// steer clear of the surrogate block
						if (cp >= 21'h00D800 && cp <= 21'h00DFFF)
							cp = cp ^ 21'h002000;
					end
					default: cp = CpW'($urandom_range('h10000, 'h10FFFF));
				endcase
				case (len)
					1: w.b0 = cp[7:0];
					2: begin
						w.b0 = {3'b110, cp[10:6]};
						w.b1 = {2'b10, cp[5:0]};
					end
					3: begin
						w.b0 = {4'b1110, cp[15:12]};
						w.b1 = {2'b10, cp[11:6]};
						w.b2 = {2'b10, cp[5:0]};
					end
					default: begin
						w.b0 = {5'b11110, cp[20:18]};
						w.b1 = {2'b10, cp[17:12]};
						w.b2 = {2'b10, cp[11:6]};
						w.b3 = {2'b10, cp[5:0]};
					end
				endcase
				if (len > 1 && $urandom_range(0, 7) == 0)
					w.avail = AvW'($urandom_range(0, len - 1));
				else
					w.avail = AvW'($urandom_range(len, 7));
				// corrupt one trailing byte
				if (kind == BROKEN && len > 1) begin
					case ($urandom_range(1, len - 1))
						1: w.b1 = 8'($urandom);
						2: w.b2 = 8'($urandom);
						default: w.b3 = 8'($urandom);
					endcase
				end
			end
			pending_windows.insert(pending_windows.size(), w);
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_windows.size() != 0 || s_tvalid)
			@(negedge clk);
		waited = 0;
		while (expected_chars.size() != 0 && waited < 5000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
		if (expected_chars.size() != 0)
			report_mismatch("words still expected", 0, expected_chars.size());

		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
